### src/gsppm_pkg.sv
// Shared types, widths and constants of the gas sensor ppm conversion pipeline.
// No dependencies; every other file of the block imports it.
`default_nettype none

package gsppm_pkg;

    localparam int ADC_BITS   = 12;
    localparam int OHM_W      = 20;
    localparam int COEF_W     = 16;
    localparam int RES_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = OHM_W;

    // Rs numerator / denominator products
    localparam int PROD_W = OHM_W + ADC_BITS;

    // log2 in Q.20: integer part indexes the leading one of a PROD_W word
    localparam int LOG_FRAC = 20;
    localparam int LOG_INT  = $clog2(PROD_W);
    localparam int LOG_W    = LOG_INT + LOG_FRAC;
    localparam int LOG_LAT  = LOG_FRAC + 1;
    localparam int MANT_W   = 31;

    // pipelined restoring divider
    localparam int DIV_NW  = PROD_W + 16;
    localparam int DIV_DW  = PROD_W;
    localparam int DIV_QW  = 26;
    localparam int DIV_LAT = DIV_QW + 1;

    localparam int RATIO_FRAC = 16;
    localparam int DIFF_W     = LOG_W + 3;
    localparam int BPROD_W    = COEF_W + 23;
    localparam int BB_W       = 27;
    localparam int SLOPE_FRAC = 12;

    // 2^z: z in Q.20, valid window -9 .. 16
    localparam int EXP_STEPS = 20;
    localparam int EXP_U_W   = 25;
    localparam int ACC_W     = 32;
    localparam logic [DIV_QW-1:0] EXP_HI = DIV_QW'(16 << LOG_FRAC);
    localparam logic [DIV_QW-1:0] EXP_LO = DIV_QW'(9 << LOG_FRAC);

    localparam logic [RES_W-1:0] SAT24        = '1;
    localparam logic [21:0]      LOG2_TEN_Q20 = 22'd3483294;

    // pipeline stage positions, counted from the input register
    localparam int ST_LOG   = LOG_LAT;
    localparam int ST_DIFF  = ST_LOG + 1;
    localparam int ST_MNUM  = ST_DIFF + 1;
    localparam int ST_MDIV  = ST_MNUM + DIV_LAT;
    localparam int ST_EXP0  = ST_MDIV + 1;
    localparam int ST_EXPN  = ST_EXP0 + EXP_STEPS;
    localparam int ST_LAST  = ST_EXPN + 1;
    localparam int ST_RC_IN = ST_LAST - DIV_LAT;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOAD, CFG_CLEAN_AIR, CFG_FULL_SCALE, CFG_SLOPE, CFG_INTERCEPT, CFG_THRESHOLD
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK, ST_ZERO_SAMPLE, ST_FULL_SCALE, ST_ZERO_SLOPE
    } t_status;

    typedef struct packed {
        logic                op;
        logic [ADC_BITS-1:0] smp;
        logic [PROD_W-1:0]   num;
        logic [PROD_W-1:0]   den;
        t_status             stat;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] v;
        v = x;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q.30, by k successive square roots of 2
    function automatic logic [ACC_W-1:0] exp_root(input int k);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 0; i < k; i++) r = isqrt64(r << 30);
        return r[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/gsppm_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on gsppm_pkg for widths; flags quotients wider than DIV_QW bits.
`default_nettype none

module gsppm_div import gsppm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_QW-1:0] o_quot,
    output logic              o_ovf
);

    logic [DIV_DW-1:0] r_rem [0:DIV_QW];
    logic [DIV_DW-1:0] n_rem [0:DIV_QW];
    logic [DIV_QW-1:0] r_low [0:DIV_QW];
    logic [DIV_QW-1:0] n_low [0:DIV_QW];
    logic [DIV_QW-1:0] r_q   [0:DIV_QW];
    logic [DIV_QW-1:0] n_q   [0:DIV_QW];
    logic [DIV_DW-1:0] r_d   [0:DIV_QW];
    logic [DIV_DW-1:0] n_d   [0:DIV_QW];
    logic              r_ovf [0:DIV_QW];
    logic              n_ovf [0:DIV_QW];

    always_comb begin
        logic [DIV_DW:0] t;
        logic            ge;
        n_rem[0] = DIV_DW'(i_num[DIV_NW-1:DIV_QW]);
        n_ovf[0] = DIV_DW'(i_num[DIV_NW-1:DIV_QW]) >= i_den;
        n_low[0] = i_num[DIV_QW-1:0];
        n_q[0]   = '0;
        n_d[0]   = i_den;
        for (int k = 1; k <= DIV_QW; k++) begin
            t        = {r_rem[k-1], r_low[k-1][DIV_QW-1]};
            ge       = t >= {1'b0, r_d[k-1]};
            n_rem[k] = ge ? DIV_DW'(t - {1'b0, r_d[k-1]}) : t[DIV_DW-1:0];
            n_q[k]   = {r_q[k-1][DIV_QW-2:0], ge};
            n_low[k] = r_low[k-1] << 1;
            n_d[k]   = r_d[k-1];
            n_ovf[k] = r_ovf[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= DIV_QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_q[k]   <= n_q[k];
                r_d[k]   <= n_d[k];
                r_ovf[k] <= n_ovf[k];
            end
        end
    end

    assign o_quot = r_q[DIV_QW];
    assign o_ovf  = r_ovf[DIV_QW];

endmodule

`default_nettype wire

### src/gsppm_log2.sv
// Pipelined log2 in Q.20: normalize stage, then one squaring per fraction bit.
// Depends on gsppm_pkg for widths; input must be nonzero for a meaningful result.
`default_nettype none

module gsppm_log2 import gsppm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PROD_W-1:0] i_x,
    output logic [LOG_W-1:0]  o_log
);

    logic [MANT_W-1:0]   r_m   [0:LOG_FRAC];
    logic [MANT_W-1:0]   n_m   [0:LOG_FRAC];
    logic [LOG_INT-1:0]  r_int [0:LOG_FRAC];
    logic [LOG_INT-1:0]  n_int [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] r_fr  [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] n_fr  [0:LOG_FRAC];

    always_comb begin
        logic [LOG_INT-1:0]       p;
        logic [PROD_W+MANT_W-2:0] wide;
        logic [2*MANT_W-1:0]      sq;
        logic [MANT_W:0]          hi;
        p = '0;
        for (int i = 0; i < PROD_W; i++) begin
            if (i_x[i]) p = LOG_INT'(i);
        end
        // mantissa with its leading one at bit 30, truncated
        wide     = {i_x, (MANT_W-1)'(0)} >> p;
        n_m[0]   = wide[MANT_W-1:0];
        n_int[0] = p;
        n_fr[0]  = '0;
        for (int k = 1; k <= LOG_FRAC; k++) begin
            sq       = r_m[k-1] * r_m[k-1];
            hi       = sq[2*MANT_W-1:MANT_W-1];
            n_m[k]   = hi[MANT_W] ? hi[MANT_W:1] : hi[MANT_W-1:0];
            n_fr[k]  = {r_fr[k-1][LOG_FRAC-2:0], hi[MANT_W]};
            n_int[k] = r_int[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k <= LOG_FRAC; k++) begin
                r_m[k]   <= n_m[k];
                r_int[k] <= n_int[k];
                r_fr[k]  <= n_fr[k];
            end
        end
    end

    assign o_log = {r_int[LOG_FRAC], r_fr[LOG_FRAC]};

endmodule

`default_nettype wire

### src/gas_sensor_ppm_conversion.sv
// Top level of the gas sensor ppm conversion: config registers and main pipeline.
// Depends on gsppm_pkg, gsppm_log2 and gsppm_div.
//
// Usage:
//   Input channel (i_valid / o_stall) carries op and one ADC sample; a
//   transaction completes on an edge with valid high and stall low.
//   Output channel (o_valid / i_stall) carries result value, Rs/Ro ratio,
//   danger flag and status, one result per input transaction.
//   Config channel (i_cfg_valid / o_cfg_ready) writes register i_cfg_index;
//   ready is always high. Write only while no transaction is in flight.
// Depth: 74 register stages, from the input register to the result register.
//   The depth is set by the log2 squaring chain (21), the slope
//   division (27 stages, one quotient bit in each after the first) and the
//   2^x root-multiply chain (21).
// Throughput: one transaction per cycle while the output is not stalled.
// Reset (synchronous, active low) empties the pipeline and loads the
//   default calibration registers.
// Stall: while a result waits under i_stall, the whole pipeline holds and
//   o_stall is raised; nothing is dropped or repeated.
`default_nettype none

module gas_sensor_ppm_conversion import gsppm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_op,
    input  logic [ADC_BITS-1:0]   i_adc_sample,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [RES_W-1:0]      o_result_value,
    output logic [RES_W-1:0]      o_resistance_ratio,
    output logic                  o_danger,
    output logic [1:0]            o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                     adv;

    logic [OHM_W-1:0]         r_load;
    logic [OHM_W-1:0]         r_ro;
    logic [ADC_BITS-1:0]      r_fs;
    logic signed [COEF_W-1:0] r_slope;
    logic signed [COEF_W-1:0] r_icpt;
    logic [COEF_W-1:0]        r_thr;

    logic signed [BPROD_W-1:0] r_bprod;
    logic signed [BB_W-1:0]    r_bb;
    logic [BPROD_W-1:0]        bmag;
    logic [BPROD_W-1:0]        bq;
    logic [COEF_W-1:0]         slope_mag;

    t_side r_side [0:ST_LAST];
    t_side n_side;
    logic  r_vld  [0:ST_LAST];

    logic [LOG_W-1:0] log_num;
    logic [LOG_W-1:0] log_den;

    logic signed [DIFF_W-1:0] r_diff;
    logic [DIFF_W-1:0]        diff_mag;
    logic [DIV_NW-1:0]        r_mnum;
    logic                     r_mneg [0:DIV_LAT];
    logic [DIV_QW-1:0]        mdiv_q;
    logic                     mdiv_ovf;

    logic [DIV_NW-1:0] rat_num;
    logic [DIV_QW-1:0] rat_q;
    logic              rat_ovf;
    logic [DIV_NW-1:0] cal_num;
    logic [DIV_DW-1:0] cal_den;
    logic [DIV_QW-1:0] cal_q;
    logic              cal_ovf;

    logic [ACC_W-1:0]     r_e_acc  [0:EXP_STEPS];
    logic [LOG_FRAC-1:0]  r_e_frac [0:EXP_STEPS];
    logic [EXP_U_W-LOG_FRAC-1:0] r_e_iu [0:EXP_STEPS];
    logic                 r_e_sat  [0:EXP_STEPS];
    logic                 r_e_zero [0:EXP_STEPS];
    logic [DIV_QW-1:0]    e_u;
    logic [RES_W-1:0]     r_exp_res;
    logic [EXP_U_W-LOG_FRAC-1:0] sh;
    logic [ACC_W:0]       rnd;
    logic [ACC_W:0]       vsh;

    logic                 r_out_vld;
    logic [RES_W-1:0]     r_res;
    logic [RES_W-1:0]     r_ratio;
    logic                 r_danger;
    t_status              r_status;
    logic [RES_W-1:0]     n_res;
    logic [RES_W-1:0]     n_ratio;
    logic                 n_danger;
    t_status              n_status;

    // whole pipeline moves unless the held result is stalled
    assign adv         = !r_out_vld || !i_stall;
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= OHM_W'(10000);
            r_ro    <= OHM_W'(10000);
            r_fs    <= ADC_BITS'(4095);
            r_slope <= -COEF_W'(1925);
            r_icpt  <= COEF_W'(5775);
            r_thr   <= COEF_W'(310);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOAD:       r_load  <= i_cfg_data[OHM_W-1:0];
                CFG_CLEAN_AIR:  r_ro    <= i_cfg_data[OHM_W-1:0];
                CFG_FULL_SCALE: r_fs    <= i_cfg_data[ADC_BITS-1:0];
                CFG_SLOPE:      r_slope <= i_cfg_data[COEF_W-1:0];
                CFG_INTERCEPT:  r_icpt  <= i_cfg_data[COEF_W-1:0];
                CFG_THRESHOLD:  r_thr   <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // b * log2(10), rounded half away from zero to Q.20
    assign bmag      = r_bprod[BPROD_W-1] ? BPROD_W'(-r_bprod) : BPROD_W'(r_bprod);
    assign bq        = (bmag + BPROD_W'(2048)) >> SLOPE_FRAC;
    assign slope_mag = r_slope[COEF_W-1] ? COEF_W'(-r_slope) : COEF_W'(r_slope);

    always_ff @(posedge i_clk) begin
        r_bprod <= BPROD_W'(r_icpt) * BPROD_W'($signed({1'b0, LOG2_TEN_Q20}));
        r_bb    <= r_bprod[BPROD_W-1] ? -$signed(BB_W'(bq)) : $signed(BB_W'(bq));
    end

    // ---------------- input stage ----------------
    always_comb begin
        n_side.op  = i_op;
        n_side.smp = i_adc_sample;
        n_side.num = PROD_W'(r_load) * PROD_W'(ADC_BITS'(r_fs - i_adc_sample));
        n_side.den = PROD_W'(i_adc_sample) * PROD_W'(r_ro);
        if (i_adc_sample == '0) begin
            n_side.stat = ST_ZERO_SAMPLE;
        end else if (i_adc_sample >= r_fs) begin
            n_side.stat = ST_FULL_SCALE;
        end else begin
            n_side.stat = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ST_LAST; k++) r_vld[k] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= ST_LAST; k++) r_vld[k] <= r_vld[k-1];
            r_out_vld <= r_vld[ST_LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            for (int k = 1; k <= ST_LAST; k++) r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- log2(num) - log2(den) ----------------
    gsppm_log2 u_log_num (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_side[0].num),
        .o_log (log_num)
    );

    gsppm_log2 u_log_den (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_x   (r_side[0].den),
        .o_log (log_den)
    );

    assign diff_mag = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_diff    <= $signed({3'b0, log_num}) - $signed({3'b0, log_den})
                         - DIFF_W'(r_bb);
            r_mnum    <= (DIV_NW'(diff_mag) << SLOPE_FRAC) + DIV_NW'(slope_mag >> 1);
            r_mneg[0] <= r_diff[DIFF_W-1] ^ r_slope[COEF_W-1];
            for (int k = 1; k <= DIV_LAT; k++) r_mneg[k] <= r_mneg[k-1];
        end
    end

    // ---------------- division by slope ----------------
    gsppm_div u_div_slope (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (r_mnum),
        .i_den  (DIV_DW'(slope_mag)),
        .o_quot (mdiv_q),
        .o_ovf  (mdiv_ovf)
    );

    // ---------------- 2^z ----------------
    assign e_u = r_mneg[DIV_LAT] ? (EXP_LO - mdiv_q) : (EXP_LO + mdiv_q);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_acc[0]  <= ACC_W'(1) << 30;
            r_e_frac[0] <= e_u[LOG_FRAC-1:0];
            r_e_iu[0]   <= e_u[EXP_U_W-1:LOG_FRAC];
            r_e_sat[0]  <= !r_mneg[DIV_LAT] && (mdiv_ovf || mdiv_q >= EXP_HI);
            r_e_zero[0] <= r_mneg[DIV_LAT] && (mdiv_ovf || mdiv_q > EXP_LO);
        end
    end

    for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
        localparam logic [ACC_W-1:0] ROOT = exp_root(k);
        logic [2*ACC_W-2:0] prod;
        assign prod = (2*ACC_W-1)'(r_e_acc[k-1]) * (2*ACC_W-1)'(ROOT)
                      + ((2*ACC_W-1)'(1) << 29);
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_e_acc[k]  <= r_e_frac[k-1][EXP_STEPS-k] ? prod[ACC_W+29:30]
                                                          : r_e_acc[k-1];
                r_e_frac[k] <= r_e_frac[k-1];
                r_e_iu[k]   <= r_e_iu[k-1];
                r_e_sat[k]  <= r_e_sat[k-1];
                r_e_zero[k] <= r_e_zero[k-1];
            end
        end
    end

    // round Q.30 mantissa to Q16.8 at the integer exponent
    assign sh  = 5'd31 - r_e_iu[EXP_STEPS];
    assign rnd = {1'b0, r_e_acc[EXP_STEPS]} + ((ACC_W+1)'(1) << (sh - 5'd1));
    assign vsh = rnd >> sh;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_e_sat[EXP_STEPS]) begin
                r_exp_res <= SAT24;
            end else if (r_e_zero[EXP_STEPS]) begin
                r_exp_res <= '0;
            end else if (vsh > (ACC_W+1)'(SAT24)) begin
                r_exp_res <= SAT24;
            end else begin
                r_exp_res <= vsh[RES_W-1:0];
            end
        end
    end

    // ---------------- ratio and calibration divisions ----------------
    assign rat_num = (DIV_NW'(r_side[ST_RC_IN].num) << RATIO_FRAC)
                     + DIV_NW'(r_side[ST_RC_IN].den >> 1);
    assign cal_num = (DIV_NW'(r_side[ST_RC_IN].num) << 2) + DIV_NW'(r_side[ST_RC_IN].num)
                     + (DIV_NW'(r_side[ST_RC_IN].smp) << 4)
                     + (DIV_NW'(r_side[ST_RC_IN].smp) << 3);
    assign cal_den = (DIV_DW'(r_side[ST_RC_IN].smp) << 5)
                     + (DIV_DW'(r_side[ST_RC_IN].smp) << 4);

    gsppm_div u_div_ratio (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (rat_num),
        .i_den  (r_side[ST_RC_IN].den),
        .o_quot (rat_q),
        .o_ovf  (rat_ovf)
    );

    gsppm_div u_div_cal (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (cal_num),
        .i_den  (cal_den),
        .o_quot (cal_q),
        .o_ovf  (cal_ovf)
    );

    // ---------------- result merge ----------------
    always_comb begin
        logic num_zero;
        logic den_zero;
        num_zero = r_side[ST_LAST].num == '0;
        den_zero = r_side[ST_LAST].den == '0;
        n_res    = '0;
        n_ratio  = '0;
        n_danger = 1'b0;
        n_status = r_side[ST_LAST].stat;
        if (r_side[ST_LAST].stat == ST_OK) begin
            if (num_zero) begin
                n_ratio = '0;
            end else if (den_zero || rat_ovf || rat_q > DIV_QW'(SAT24)) begin
                n_ratio = SAT24;
            end else begin
                n_ratio = rat_q[RES_W-1:0];
            end
            if (r_side[ST_LAST].op) begin
                n_res = (cal_ovf || cal_q > DIV_QW'(SAT24)) ? SAT24 : cal_q[RES_W-1:0];
            end else if (r_slope == '0) begin
                n_status = ST_ZERO_SLOPE;
            end else begin
                if (num_zero) begin
                    n_res = r_slope[COEF_W-1] ? SAT24 : '0;
                end else if (den_zero) begin
                    n_res = r_slope[COEF_W-1] ? '0 : SAT24;
                end else begin
                    n_res = r_exp_res;
                end
                n_danger = n_res > {r_thr, 8'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res    <= n_res;
            r_ratio  <= n_ratio;
            r_danger <= n_danger;
            r_status <= n_status;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_result_value     = r_res;
    assign o_resistance_ratio = r_ratio;
    assign o_danger           = r_danger;
    assign o_status           = r_status;

endmodule

`default_nettype wire

### src/gsppm_chk.sv
// Port-level checker for gas_sensor_ppm_conversion, attached by bind.
// Depends on gsppm_pkg for widths and status codes.
`default_nettype none

module gsppm_chk import gsppm_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_stall,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [RES_W-1:0]      o_result_value,
    input wire logic [RES_W-1:0]      o_resistance_ratio,
    input wire logic                  o_danger,
    input wire logic [1:0]            o_status
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output transaction dropped under stall");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result_value) && $stable(o_resistance_ratio)
                               && $stable(o_danger) && $stable(o_status))
        else $error("stalled output changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_ZERO_SAMPLE || o_status == ST_FULL_SCALE)
        |-> o_result_value == '0 && o_resistance_ratio == '0 && !o_danger)
        else $error("bad-sample result not cleared");

    a_danger_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_danger |-> o_status == ST_OK)
        else $error("danger raised with error status");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without held output");

endmodule

bind gas_sensor_ppm_conversion gsppm_chk u_gsppm_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_result_value     (o_result_value),
    .o_resistance_ratio (o_resistance_ratio),
    .o_danger           (o_danger),
    .o_status           (o_status)
);

`default_nettype wire

### test/gsppm_checker.sv
// Checker for gas_sensor_ppm_conversion: watches config, input and output channels,
// predicts each result in fixed point and compares. Depends on gsppm_pkg.
`timescale 1ns / 1ps

module gsppm_checker import gsppm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_in_stall,
    input  logic                  i_op,
    input  logic [ADC_BITS-1:0]   i_adc_sample,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [RES_W-1:0]      i_result_value,
    input  logic [RES_W-1:0]      i_resistance_ratio,
    input  logic                  i_danger,
    input  logic [1:0]            i_status,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic [RES_W-1:0] ratio;
        logic             danger;
        t_status          status;
    } t_reading;

    logic [19:0] load_ohm, ro_ohm;
    logic [11:0] full_scale;
    logic signed [15:0] slope, icept;
    logic [15:0] thresh;
    t_reading readings_due[$];

    function automatic longint rnd_div(longint n, longint d);
        longint un, ud, q;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint sq_root(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint log2_fix(logic [63:0] x);
        int p;
        logic [63:0] mt;
        longint res;
        p = 63;
        while (x[p] == 1'b0) p--;
        mt = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        res = longint'(p) * 1048576;
        for (int i = 19; i >= 0; i--) begin
            mt = (mt * mt) >> 30;
            if (mt >= (64'd1 << 31)) begin
                mt = mt >> 1;
                res += longint'(1) << i;
            end
        end
        return res;
    endfunction

    function automatic logic [RES_W-1:0] pow2_fix(longint z);
        logic [63:0] u, fr, acc, r, v;
        int ip, sh;
        acc = 64'd1 << 30;
        r = 64'd1 << 31;
        if (z >= 16 * 1048576) return SAT24;
        if (z < -9 * 1048576) return '0;
        u = z + 9 * 1048576;
        ip = int'(u >> 20) - 9;
        fr = u & 64'hFFFFF;
        for (int k = 1; k <= 20; k++) begin
            r = sq_root(r << 30);
            if (fr[20-k]) acc = (acc * r + (64'd1 << 29)) >> 30;
        end
        sh = 22 - ip;
        v = (acc + (64'd1 << (sh - 1))) >> sh;
        return v > SAT24 ? SAT24 : v[RES_W-1:0];
    endfunction

    function automatic t_reading convert_sample(logic op, logic [11:0] s);
        t_reading e;
        logic [63:0] num, den, ratio, res;
        longint y, bb, z;
        e = '0;
        res = 0;
        if (s == 0) begin
            e.status = ST_ZERO_SAMPLE;
            return e;
        end
        if (s >= full_scale) begin
            e.status = ST_FULL_SCALE;
            return e;
        end
        num = 64'(load_ohm) * 64'(full_scale - s);
        den = 64'(s) * 64'(ro_ohm);
        if (num == 0) ratio = 0;
        else if (den == 0) ratio = SAT24;
        else begin
            ratio = ((num << 16) + den / 2) / den;
            if (ratio > SAT24) ratio = SAT24;
        end
        e.ratio = ratio[RES_W-1:0];
        if (op) begin
            res = (num * 5 + 24 * s) / (48 * s);
            if (res > SAT24) res = SAT24;
        end else if (slope == 0) begin
            e.status = ST_ZERO_SLOPE;
        end else begin
            if (num == 0) res = slope < 0 ? SAT24 : 0;
            else if (den == 0) res = slope > 0 ? SAT24 : 0;
            else begin
                y = log2_fix(num) - log2_fix(den);
                bb = rnd_div(longint'(icept) * 3483294, 4096);
                z = rnd_div((y - bb) * 4096, longint'(slope));
                res = pow2_fix(z);
            end
            e.danger = res > (64'(thresh) << 8);
        end
        e.value = res[RES_W-1:0];
        return e;
    endfunction

    assign o_pending = readings_due.size();

    always @(posedge i_clk) begin
        t_reading got, want;
        if (!i_rst_n) begin
            load_ohm <= 20'd10000;
            ro_ohm <= 20'd10000;
            full_scale <= 12'd4095;
            slope <= -16'sd1925;
            icept <= 16'sd5775;
            thresh <= 16'd310;
            readings_due.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LOAD:       load_ohm <= i_cfg_data;
                    CFG_CLEAN_AIR:  ro_ohm <= i_cfg_data;
                    CFG_FULL_SCALE: full_scale <= i_cfg_data[11:0];
                    CFG_SLOPE:      slope <= i_cfg_data[15:0];
                    CFG_INTERCEPT:  icept <= i_cfg_data[15:0];
                    CFG_THRESHOLD:  thresh <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall)
                readings_due.push_back(convert_sample(i_op, i_adc_sample));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_result_value, i_resistance_ratio, i_danger, t_status'(i_status)};
                if (readings_due.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = readings_due.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10) $display("mismatch exp %p act %p", want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

### test/tb_top.sv
// Stimulus and verdict for gas_sensor_ppm_conversion.
// Depends on gsppm_pkg, the block and gsppm_checker.
`timescale 1ns / 1ps

module tb_top;
    import gsppm_pkg::*;

    localparam int LATENCY = 74;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_valid = 1'b0, i_op = 1'b0, i_stall = 1'b0;
    logic [ADC_BITS-1:0] i_adc_sample = '0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_danger, o_cfg_ready;
    logic [RES_W-1:0] o_result_value, o_resistance_ratio;
    logic [1:0] o_status;
    int errors, pending, idle_cycles, rx_left;
    bit hold_rx = 1'b0;

    always #5 i_clk = ~i_clk;

    gas_sensor_ppm_conversion dut (.*);

    gsppm_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_op, .i_adc_sample,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_result_value(o_result_value),
        .i_resistance_ratio(o_resistance_ratio), .i_danger(o_danger), .i_status(o_status),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, now and then a long one, or a hold when requested
    always @(posedge i_clk) begin
        if (hold_rx) begin
            i_stall <= 1'b1;
        end else if (rx_left > 0) begin
            i_stall <= 1'b1;
            rx_left <= rx_left - 1;
        end else if ($urandom_range(0, 299) == 0) begin
            i_stall <= 1'b1;
            rx_left <= $urandom_range(10, 40);
        end else begin
            i_stall <= ($urandom_range(0, 99) < 25) ? ($urandom_range(0, 9) < 8) : 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send(logic op, logic [ADC_BITS-1:0] s, bit no_gap);
        int g;
        i_valid <= 1'b1;
        i_op <= op;
        i_adc_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            i_op <= 1'($urandom());
            i_adc_sample <= ADC_BITS'($urandom());
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_curve(logic [19:0] rl, logic [19:0] ro, logic [11:0] fs,
                             logic [15:0] m, logic [15:0] b, logic [15:0] th);
        write_reg(CFG_LOAD, rl);
        write_reg(CFG_CLEAN_AIR, ro);
        write_reg(CFG_FULL_SCALE, CFG_DATA_W'(fs));
        write_reg(CFG_SLOPE, CFG_DATA_W'(m));
        write_reg(CFG_INTERCEPT, CFG_DATA_W'(b));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(th));
    endtask

    task automatic random_samples(int n, logic [11:0] fs);
        int r;
        logic [11:0] s;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) s = '0;
            else if (r < 7) s = 12'(fs + 12'($urandom_range(0, 2)));
            else if (r < 15) s = 12'($urandom());
            else if (fs > 1) s = 12'($urandom_range(1, fs - 1));
            else s = 12'($urandom());
            send($urandom_range(0, 3) == 0, s, 1'b0);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset calibration
        send(1'b0, 12'd0, 1'b0);
        send(1'b0, 12'd4095, 1'b0);
        send(1'b0, 12'd1, 1'b0);
        send(1'b0, 12'd4094, 1'b0);
        send(1'b0, 12'd2048, 1'b0);
        send(1'b0, 12'd300, 1'b0);
        send(1'b1, 12'd1, 1'b0);
        send(1'b1, 12'd2048, 1'b0);
        send(1'b1, 12'd4094, 1'b0);
        send(1'b1, 12'd0, 1'b0);
        drain();
        // zero slope, extremes
        set_curve(20'hFFFFF, 20'd1, 12'd4095, 16'd0, 16'h8000, 16'hFFFF);
        send(1'b0, 12'd1, 1'b0);
        send(1'b1, 12'd1, 1'b0);
        send(1'b0, 12'd4000, 1'b0);
        drain();
        // zero load and zero clean-air, both slope signs
        set_curve(20'd0, 20'd0, 12'd1, 16'h7FFF, 16'h7FFF, 16'd0);
        send(1'b0, 12'd0, 1'b0);
        send(1'b0, 12'd1, 1'b0);
        send(1'b0, 12'd2, 1'b0);
        drain();
        set_curve(20'd0, 20'd5, 12'd100, 16'h8000, 16'd0, 16'd0);
        send(1'b0, 12'd50, 1'b0);
        send(1'b1, 12'd50, 1'b0);
        drain();
        set_curve(20'd7, 20'd0, 12'd100, 16'h7FFF, 16'd0, 16'd0);
        send(1'b0, 12'd50, 1'b0);
        drain();
        write_reg(CFG_SLOPE, 20'h0FFFF);
        send(1'b0, 12'd50, 1'b0);
        send(1'b0, 12'd0, 1'b0);
        drain();

        // random phases over several settings
        set_curve(20'd10000, 20'd10000, 12'd4095, -16'sd1925, 16'sd5775, 16'd310);
        random_samples(200, 12'd4095);
        // receiver held off while the sender keeps offering
        hold_rx = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            for (int i = 0; i < 120; i++) send(1'b0, 12'($urandom_range(1, 4094)), 1'b1);
        join
        drain();
        for (int p = 0; p < 4; p++) begin
            logic [11:0] fs_r;
            fs_r = 12'($urandom_range(1, 4095));
            set_curve(20'($urandom_range(1, 20'hFFFFF)), 20'($urandom_range(1, 20'hFFFFF)),
                      fs_r, 16'($urandom()), 16'($urandom()), 16'($urandom()));
            random_samples(120, fs_r);
            drain();
        end
        set_curve(20'd1, 20'hFFFFF, 12'd4095, 16'h0800, 16'hF000, 16'd1);
        random_samples(60, 12'd4095);
        drain();

        if (errors == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

endmodule

### gas_sensor_ppm_conversion.f
src/gsppm_pkg.sv
src/gsppm_div.sv
src/gsppm_log2.sv
src/gas_sensor_ppm_conversion.sv
src/gsppm_chk.sv
test/gsppm_checker.sv
test/tb_top.sv
